>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sprite chain expander.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an implication holds at every rising clock edge outside reset.
`define SCE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Checks that a condition never holds at a rising clock edge outside reset.
`define SCE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SCE_ASSERT_IMPL(label, clk, rst_n, prop)
`define SCE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> rtl/core/sce_pkg.sv
// Package with the types and constants of the sprite chain expander.
`default_nettype none
package sce_pkg;

    // Control byte bit positions.
    localparam int unsigned CTRL_DISABLE_BIT = 7;
    localparam int unsigned CTRL_FLIPY_BIT   = 4;
    localparam int unsigned CTRL_YCHAIN_BIT  = 3;

    localparam logic [15:0] PRIO_LOW_BITS = 16'h8800;
    localparam logic [6:0]  PAL_OR        = 7'h60;
    localparam logic [7:0]  MASK_HIGH_PRI = 8'hfc;
    localparam logic [7:0]  MASK_LOW_PRI  = 8'hf0;
    localparam logic [16:0] TILE_STEP     = 17'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic disabled;
        logic last;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/core/sce_datapath.sv
// Datapath of the sprite chain expander: entry registers, steppers and config.
`default_nettype none
module sce_datapath
    import sce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [7:0]  i_x_low,
    input  wire logic [7:0]  i_x_high,
    input  wire logic [7:0]  i_y_low,
    input  wire logic [7:0]  i_y_high,
    input  wire logic [7:0]  i_control_byte,
    input  wire logic [7:0]  i_tile_low,
    input  wire logic [7:0]  i_tile_high,
    input  wire logic [7:0]  i_color_byte,
    output logic [14:0]      o_tile_code,
    output logic [6:0]       o_palette,
    output logic             o_flip_vertical,
    output logic [16:0]      o_pos_x,
    output logic [16:0]      o_pos_y,
    output logic [7:0]       o_prio_mask,
    output logic             o_last_tile
);

    logic [15:0] r_prio_ctrl;
    logic [14:0] r_tile;
    logic [6:0]  r_pal;
    logic        r_flip;
    logic        r_ychain;
    logic [16:0] r_px;
    logic [16:0] r_py;
    logic [2:0]  r_remain;

    logic [16:0] n_px_load;
    logic [16:0] n_py_load;
    logic [16:0] w_y_offset;
    logic        w_flip_in;
    logic        w_ychain_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_ctrl <= 16'h0000;
        end else if (i_cfg_we) begin
            r_prio_ctrl <= i_cfg_data;
        end
    end

    assign w_flip_in   = i_control_byte[CTRL_FLIPY_BIT];
    assign w_ychain_in = i_control_byte[CTRL_YCHAIN_BIT];
    assign n_px_load   = {i_x_high[7], i_x_high, i_x_low};
    // A flipped Y chain starts at its bottom tile.
    assign w_y_offset  = (w_ychain_in && w_flip_in) ?
                         {10'd0, i_control_byte[2:0], 4'd0} : 17'd0;
    assign n_py_load   = {i_y_high[7], i_y_high, i_y_low} + w_y_offset;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tile   <= {1'b0, i_tile_high[5:0], i_tile_low};
            r_pal    <= {3'b000, i_color_byte[3:0]} | PAL_OR;
            r_flip   <= w_flip_in;
            r_ychain <= w_ychain_in;
            r_px     <= n_px_load;
            r_py     <= n_py_load;
            r_remain <= i_control_byte[2:0];
        end else if (i_cmd.step) begin
            r_tile   <= r_tile + 15'd1;
            r_remain <= r_remain - 3'd1;
            if (r_ychain) begin
                r_py <= r_flip ? (r_py - TILE_STEP) : (r_py + TILE_STEP);
            end else begin
                r_px <= r_px + TILE_STEP;
            end
        end
    end

    assign o_status.disabled = i_control_byte[CTRL_DISABLE_BIT];
    assign o_status.last     = (r_remain == 3'd0);

    assign o_tile_code     = r_tile;
    assign o_palette       = r_pal;
    assign o_flip_vertical = r_flip;
    assign o_pos_x         = r_px;
    assign o_pos_y         = r_py;
    assign o_prio_mask     = ((r_prio_ctrl & PRIO_LOW_BITS) != 16'h0000) ?
                             MASK_LOW_PRI : MASK_HIGH_PRI;
    assign o_last_tile     = (r_remain == 3'd0);

endmodule
`default_nettype wire

>>> rtl/core/sce_controller.sv
// Controller state machine of the sprite chain expander.
`default_nettype none
module sce_controller
    import sce_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;
    logic w_done;

    // The last command leaving frees the block for the next request at once.
    assign w_done     = (r_state == ST_RUN) && i_out_ready && i_status.last;
    assign o_in_ready = (r_state == ST_IDLE) || w_done;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_RUN);

    assign o_cmd.load = w_accept && !i_status.disabled;
    assign o_cmd.step = (r_state == ST_RUN) && i_out_ready && !i_status.last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_done && !o_cmd.load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sprite_chain_expander_core.sv
// Top level of the sprite chain expander: controller plus datapath.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------
//  entry    | in        | i_valid / o_ready  | eight sprite entry bytes
//  command  | out       | o_valid / i_ready  | tile, palette, flip, x, y, mask, last
//  config   | in        | i_cfg_we           | i_cfg_data (priority control word)
//
// An enabled entry gives chain size plus one draw commands, one to eight, one per
// cycle while i_ready is high; the command register and its stepper make them.
// A disabled entry is taken and gives no command.
// Reset is synchronous and active low; it clears the state and the priority word.
// A stall on the command side holds the current command; a new request is taken
// in the same cycle that the last command of the chain is taken.
`default_nettype none
`include "assert_macros.svh"
module sprite_chain_expander_core
    import sce_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_x_low,
    input  wire logic [7:0]         i_x_high,
    input  wire logic [7:0]         i_y_low,
    input  wire logic [7:0]         i_y_high,
    input  wire logic [7:0]         i_control_byte,
    input  wire logic [7:0]         i_tile_low,
    input  wire logic [7:0]         i_tile_high,
    input  wire logic [7:0]         i_color_byte,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [14:0]             o_tile_code,
    output logic [6:0]              o_palette,
    output logic                    o_flip_vertical,
    output logic signed [16:0]      o_pos_x,
    output logic signed [16:0]      o_pos_y,
    output logic [7:0]              o_prio_mask,
    output logic                    o_last_tile
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [16:0] w_pos_x;
    logic [16:0] w_pos_y;

    // The controller sequences one entry at a time through the datapath.
    sce_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath registers hold the command on show and step to the next one.
    sce_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_x_low         (i_x_low),
        .i_x_high        (i_x_high),
        .i_y_low         (i_y_low),
        .i_y_high        (i_y_high),
        .i_control_byte  (i_control_byte),
        .i_tile_low      (i_tile_low),
        .i_tile_high     (i_tile_high),
        .i_color_byte    (i_color_byte),
        .o_tile_code     (o_tile_code),
        .o_palette       (o_palette),
        .o_flip_vertical (o_flip_vertical),
        .o_pos_x         (w_pos_x),
        .o_pos_y         (w_pos_y),
        .o_prio_mask     (o_prio_mask),
        .o_last_tile     (o_last_tile)
    );

    assign o_pos_x = $signed(w_pos_x);
    assign o_pos_y = $signed(w_pos_y);

    // No new request is taken while a chain still has commands to give.
    `SCE_ASSERT_NEVER(a_no_accept_mid_chain, i_clk, i_rst_n, o_valid && !o_last_tile && o_ready)

    // Taking a command that is not the last moves on to the next tile code.
    `SCE_ASSERT_IMPL(a_tile_steps, i_clk, i_rst_n, (o_valid && !o_last_tile && i_ready) |=> (o_valid && (o_tile_code == 15'($past(o_tile_code) + 15'd1))))

    // Taking the last command without a new request leaves the output empty.
    `SCE_ASSERT_IMPL(a_chain_ends, i_clk, i_rst_n, (o_valid && o_last_tile && i_ready && !i_valid) |=> !o_valid)

endmodule
`default_nettype wire
